// ===== rtl/qaau_pkg.sv =====
`default_nettype none
package qaau_pkg;

    typedef struct packed {
        logic signed [31:0] rot_x;
        logic signed [31:0] rot_y;
        logic signed [31:0] rot_z;
        logic signed [31:0] att_x;
        logic signed [31:0] att_y;
        logic signed [31:0] att_z;
        logic signed [31:0] att_w;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic signed [31:0] new_z;
        logic signed [31:0] new_w;
    } out_item_t;

    localparam int NUM_SQRT = 32;
    localparam int NUM_DIV  = 30;
    localparam int NUM_COS  = 7;
    localparam int NUM_SIN  = 6;

    localparam logic [31:0] ONE31    = 32'h8000_0000;
    localparam logic [28:0] TURN_LO  = 29'd399252338;
    localparam logic [34:0] TURN_HI  = 35'd5;
    localparam logic [33:0] PI_K     = 34'd13493037704;
    localparam logic [29:0] OCT_HALF = 30'h2000_0000;
    localparam logic [30:0] QUAD_LEN = 31'h4000_0000;

    localparam logic [7:0] COS_DIV [NUM_COS] = '{8'd182, 8'd132, 8'd90, 8'd56,
                                                 8'd30, 8'd12, 8'd2};
    localparam logic [7:0] SIN_DIV [NUM_SIN] = '{8'd156, 8'd110, 8'd72, 8'd42,
                                                 8'd20, 8'd6};

    // floor(2^32 / d)
    localparam logic [31:0] COS_RECIP [NUM_COS] = '{
        32'(64'h1_0000_0000 / 64'd182), 32'(64'h1_0000_0000 / 64'd132),
        32'(64'h1_0000_0000 / 64'd90),  32'(64'h1_0000_0000 / 64'd56),
        32'(64'h1_0000_0000 / 64'd30),  32'(64'h1_0000_0000 / 64'd12),
        32'(64'h1_0000_0000 / 64'd2)};
    localparam logic [31:0] SIN_RECIP [NUM_SIN] = '{
        32'(64'h1_0000_0000 / 64'd156), 32'(64'h1_0000_0000 / 64'd110),
        32'(64'h1_0000_0000 / 64'd72),  32'(64'h1_0000_0000 / 64'd42),
        32'(64'h1_0000_0000 / 64'd20),  32'(64'h1_0000_0000 / 64'd6)};

endpackage
`default_nettype wire

// ===== rtl/quaternion_axis_angle_update.sv =====
// Axis-angle attitude update.
// Input channel req (req_valid/req_ready) carries a rotation vector (Q4.27)
// and an attitude quaternion (Q2.29); output channel rsp (rsp_valid/rsp_ready)
// carries the rotated quaternion (Q2.29, saturated). One rsp item per req item,
// in order.
// The pipeline is a row of cells: 32 square-root cells (one root bit each),
// three-stage Horner cells (7 in the cosine lane, 6 in the sine lane), and 30
// divider cells (one quotient bit each) per axis.
// Throughput: one item per cycle while rsp is not stalled, set by that fully pipelined row.
// The last stage is the output register. When rsp is stalled the whole row
// holds and req_ready drops; req_ready is high whenever the output register is
// empty or being taken.
// Reset (rst_n low, asynchronous) clears all stage valid bits; items in flight
// are dropped and the block takes a new item in the first cycle after release.
`default_nettype none
module quaternion_axis_angle_update (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  qaau_pkg::in_item_t  req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output qaau_pkg::out_item_t rsp
);
    import qaau_pkg::*;

    localparam int NSTG = 97;

    typedef enum logic [1:0] {QUAD0, QUAD1, QUAD2, QUAD3} quad_t;

    typedef struct packed {
        quad_t quad;
        logic  swap;
    } ang_t;

    function automatic logic signed [31:0] to_q29(input logic [31:0] mag,
                                                  input logic neg);
        logic [32:0]        s;
        logic signed [31:0] r;
        s = {1'b0, mag} + 33'd2;
        r = signed'({1'b0, s[32:2]});
        return neg ? -r : r;
    endfunction

    logic adv;
    logic [NSTG-1:0] vld_reg;

    in_item_t           side_reg [94];
    logic [62:0]        sq_reg [3];
    logic [63:0]        sum_reg;
    logic [60:0]        lo_reg;
    logic [31:0]        len_reg [29];
    logic [31:0]        phase_reg;
    ang_t               ang_reg [24];
    logic [29:0]        rp_reg;
    logic [30:0]        x_reg;
    logic [30:0]        x2_reg;
    logic [30:0]        x39_reg;
    logic [31:0]        sm58_reg, sm59_reg, sm60_reg;
    logic signed [31:0] s29_reg;
    logic signed [31:0] c29_reg [34];
    logic signed [63:0] p_reg [3];
    logic signed [31:0] qv_reg [3];
    logic signed [63:0] pr_reg [4][4];
    logic signed [63:0] acc_reg [4];
    out_item_t          out_reg;

    // next values
    logic [63:0]        sq_full [3];
    logic [34:0]        ph_sum;
    logic [29:0]        rem30;
    logic               swap_next;
    logic [29:0]        rp_next;
    logic [63:0]        xp;
    logic [61:0]        x2p;
    logic [62:0]        smp;
    logic [31:0]        sm_sel, cm_sel;
    logic signed [31:0] s29_next, c29_next;
    logic signed [31:0] rot_d [3];
    logic signed [31:0] att_d [4];
    logic signed [31:0] qv_next [3];
    logic signed [63:0] acc_next [4];
    out_item_t          out_next;

    // cell row wiring
    logic [33:0] sq_rem_w  [NUM_SQRT+1];
    logic [31:0] sq_root_w [NUM_SQRT+1];
    logic [63:0] sq_v_w    [NUM_SQRT+1];

    logic [30:0] hc_arg_w [NUM_COS+1];
    logic [30:0] hc_aux_w [NUM_COS+1];
    logic [31:0] hc_t_w   [NUM_COS+1];
    logic [30:0] hs_arg_w [NUM_SIN+1];
    logic [30:0] hs_aux_w [NUM_SIN+1];
    logic [31:0] hs_t_w   [NUM_SIN+1];

    logic [31:0] dv_rem_w [3][NUM_DIV+1];
    logic [29:0] dv_num_w [3][NUM_DIV+1];
    logic [29:0] dv_quo_w [3][NUM_DIV+1];
    logic [31:0] dv_len_w [3][NUM_DIV+1];
    logic        dv_neg_w [3][NUM_DIV+1];

    logic [63:0] pabs [3];

    assign adv       = !vld_reg[NSTG-1] || rsp_ready;
    assign req_ready = adv;
    assign rsp_valid = vld_reg[NSTG-1];
    assign rsp       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], req_valid};
        end
    end

    // square sum, then root
    always_comb
    begin
        sq_full[0] = 64'(req.rot_x) * 64'(req.rot_x);
        sq_full[1] = 64'(req.rot_y) * 64'(req.rot_y);
        sq_full[2] = 64'(req.rot_z) * 64'(req.rot_z);
    end

    assign sq_rem_w[0]  = '0;
    assign sq_root_w[0] = '0;
    assign sq_v_w[0]    = sum_reg;

    genvar g, k;
    generate
        for (g = 0; g < NUM_SQRT; g++)
        begin : g_sqrt
            qaau_sqrt_cell u_cell (
                .clk      (clk),
                .en       (adv),
                .rem_in   (sq_rem_w[g]),
                .root_in  (sq_root_w[g]),
                .v_in     (sq_v_w[g]),
                .rem_out  (sq_rem_w[g+1]),
                .root_out (sq_root_w[g+1]),
                .v_out    (sq_v_w[g+1])
            );
        end
    endgenerate

    // phase in 2^-32 turn, quadrant, octant fold, radians
    always_comb
    begin
        ph_sum    = 35'(len_reg[0]) * TURN_HI + 35'(lo_reg[60:32]);
        rem30     = phase_reg[29:0];
        swap_next = (rem30 > OCT_HALF);
        rp_next   = swap_next ? 30'(QUAD_LEN - {1'b0, rem30}) : rem30;
        xp        = 64'(rp_reg) * 64'(PI_K);
        x2p       = 62'(x_reg) * 62'(x_reg);
        smp       = 63'(hs_aux_w[NUM_SIN]) * 63'(hs_t_w[NUM_SIN]);
    end

    assign hc_arg_w[0] = x2_reg;
    assign hc_aux_w[0] = x39_reg;
    assign hc_t_w[0]   = ONE31;
    assign hs_arg_w[0] = x2_reg;
    assign hs_aux_w[0] = x39_reg;
    assign hs_t_w[0]   = ONE31;

    generate
        for (g = 0; g < NUM_COS; g++)
        begin : g_cos
            qaau_horner_cell u_cell (
                .clk     (clk),
                .en      (adv),
                .arg_in  (hc_arg_w[g]),
                .aux_in  (hc_aux_w[g]),
                .t_in    (hc_t_w[g]),
                .dvs     (COS_DIV[g]),
                .recip   (COS_RECIP[g]),
                .arg_out (hc_arg_w[g+1]),
                .aux_out (hc_aux_w[g+1]),
                .t_out   (hc_t_w[g+1])
            );
        end
        for (g = 0; g < NUM_SIN; g++)
        begin : g_sin
            qaau_horner_cell u_cell (
                .clk     (clk),
                .en      (adv),
                .arg_in  (hs_arg_w[g]),
                .aux_in  (hs_aux_w[g]),
                .t_in    (hs_t_w[g]),
                .dvs     (SIN_DIV[g]),
                .recip   (SIN_RECIP[g]),
                .arg_out (hs_arg_w[g+1]),
                .aux_out (hs_aux_w[g+1]),
                .t_out   (hs_t_w[g+1])
            );
        end
    endgenerate

    // octant swap, then quadrant signs
    always_comb
    begin
        sm_sel = ang_reg[23].swap ? hc_t_w[NUM_COS] : sm60_reg;
        cm_sel = ang_reg[23].swap ? sm60_reg : hc_t_w[NUM_COS];
        unique case (ang_reg[23].quad)
            QUAD0:
            begin
                s29_next = to_q29(sm_sel, 1'b0);
                c29_next = to_q29(cm_sel, 1'b0);
            end
            QUAD1:
            begin
                s29_next = to_q29(cm_sel, 1'b0);
                c29_next = to_q29(sm_sel, 1'b1);
            end
            QUAD2:
            begin
                s29_next = to_q29(sm_sel, 1'b1);
                c29_next = to_q29(cm_sel, 1'b1);
            end
            QUAD3:
            begin
                s29_next = to_q29(cm_sel, 1'b1);
                c29_next = to_q29(sm_sel, 1'b0);
            end
            default:
            begin
                s29_next = '0;
                c29_next = '0;
            end
        endcase
    end

    assign rot_d[0] = side_reg[60].rot_x;
    assign rot_d[1] = side_reg[60].rot_y;
    assign rot_d[2] = side_reg[60].rot_z;

    // sin * rot_i / len, magnitude through the divider row
    generate
        for (k = 0; k < 3; k++)
        begin : g_lane
            assign pabs[k] = (p_reg[k] < 0) ? 64'(-p_reg[k]) : 64'(p_reg[k]);
            for (g = 0; g < NUM_DIV; g++)
            begin : g_div
                qaau_div_cell u_cell (
                    .clk     (clk),
                    .en      (adv),
                    .rem_in  (dv_rem_w[k][g]),
                    .num_in  (dv_num_w[k][g]),
                    .quo_in  (dv_quo_w[k][g]),
                    .len_in  (dv_len_w[k][g]),
                    .neg_in  (dv_neg_w[k][g]),
                    .rem_out (dv_rem_w[k][g+1]),
                    .num_out (dv_num_w[k][g+1]),
                    .quo_out (dv_quo_w[k][g+1]),
                    .len_out (dv_len_w[k][g+1]),
                    .neg_out (dv_neg_w[k][g+1])
                );
            end
            assign qv_next[k] = (dv_len_w[k][NUM_DIV] == '0) ? '0 :
                dv_neg_w[k][NUM_DIV] ? -signed'({2'b00, dv_quo_w[k][NUM_DIV]}) :
                signed'({2'b00, dv_quo_w[k][NUM_DIV]});
        end
    endgenerate

    // entry of the divider row (the register right after the products)
    logic [31:0] dv0_rem_reg [3];
    logic [29:0] dv0_num_reg [3];
    logic        dv0_neg_reg [3];
    logic [31:0] dv0_len_reg;

    generate
        for (k = 0; k < 3; k++)
        begin : g_dvin
            assign dv_rem_w[k][0] = dv0_rem_reg[k];
            assign dv_num_w[k][0] = dv0_num_reg[k];
            assign dv_quo_w[k][0] = '0;
            assign dv_len_w[k][0] = dv0_len_reg;
            assign dv_neg_w[k][0] = dv0_neg_reg[k];
        end
    endgenerate

    assign att_d[0] = side_reg[93].att_x;
    assign att_d[1] = side_reg[93].att_y;
    assign att_d[2] = side_reg[93].att_z;
    assign att_d[3] = side_reg[93].att_w;

    // Hamilton product sums, round half up at bit 29, saturate
    always_comb
    begin
        logic signed [63:0] rt;
        logic signed [34:0] sh;
        acc_next[0] = pr_reg[0][0] + pr_reg[0][1] + pr_reg[0][2] - pr_reg[0][3];
        acc_next[1] = pr_reg[1][0] + pr_reg[1][1] + pr_reg[1][2] - pr_reg[1][3];
        acc_next[2] = pr_reg[2][0] + pr_reg[2][1] + pr_reg[2][2] - pr_reg[2][3];
        acc_next[3] = pr_reg[3][0] - pr_reg[3][1] - pr_reg[3][2] - pr_reg[3][3];
        out_next = '0;
        for (int i = 0; i < 4; i++)
        begin
            logic signed [31:0] o;
            rt = acc_reg[i] + 64'sd268435456;
            sh = 35'(rt >>> 29);
            if (sh > 35'sd2147483647)
                o = 32'sh7fff_ffff;
            else if (sh < -35'sd2147483648)
                o = 32'sh8000_0000;
            else
                o = sh[31:0];
            unique case (i)
                0: out_next.new_x = o;
                1: out_next.new_y = o;
                2: out_next.new_z = o;
                default: out_next.new_w = o;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= req;
            for (int i = 1; i < 94; i++)
                side_reg[i] <= side_reg[i-1];
            for (int i = 0; i < 3; i++)
                sq_reg[i] <= sq_full[i][62:0];
            sum_reg <= 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);

            lo_reg     <= 61'(sq_root_w[NUM_SQRT]) * 61'(TURN_LO);
            len_reg[0] <= sq_root_w[NUM_SQRT];
            for (int i = 1; i < 29; i++)
                len_reg[i] <= len_reg[i-1];
            phase_reg <= ph_sum[31:0];

            ang_reg[0].quad <= quad_t'(phase_reg[31:30]);
            ang_reg[0].swap <= swap_next;
            for (int i = 1; i < 24; i++)
                ang_reg[i] <= ang_reg[i-1];
            rp_reg  <= rp_next;
            x_reg   <= xp[62:32];
            x2_reg  <= x2p[61:31];
            x39_reg <= x_reg;

            sm58_reg <= smp[62:31];
            sm59_reg <= sm58_reg;
            sm60_reg <= sm59_reg;

            s29_reg    <= s29_next;
            c29_reg[0] <= c29_next;
            for (int i = 1; i < 34; i++)
                c29_reg[i] <= c29_reg[i-1];

            for (int i = 0; i < 3; i++)
            begin
                p_reg[i]       <= 64'(s29_reg) * 64'(rot_d[i]);
                dv0_rem_reg[i] <= {1'b0, pabs[i][60:30]};
                dv0_num_reg[i] <= pabs[i][29:0];
                dv0_neg_reg[i] <= (p_reg[i] < 0);
                qv_reg[i]      <= qv_next[i];
            end
            dv0_len_reg <= len_reg[27];

            pr_reg[0][0] <= 64'(c29_reg[33]) * 64'(att_d[0]);
            pr_reg[0][1] <= 64'(qv_reg[0])   * 64'(att_d[3]);
            pr_reg[0][2] <= 64'(qv_reg[1])   * 64'(att_d[2]);
            pr_reg[0][3] <= 64'(qv_reg[2])   * 64'(att_d[1]);
            pr_reg[1][0] <= 64'(c29_reg[33]) * 64'(att_d[1]);
            pr_reg[1][1] <= 64'(qv_reg[1])   * 64'(att_d[3]);
            pr_reg[1][2] <= 64'(qv_reg[2])   * 64'(att_d[0]);
            pr_reg[1][3] <= 64'(qv_reg[0])   * 64'(att_d[2]);
            pr_reg[2][0] <= 64'(c29_reg[33]) * 64'(att_d[2]);
            pr_reg[2][1] <= 64'(qv_reg[2])   * 64'(att_d[3]);
            pr_reg[2][2] <= 64'(qv_reg[0])   * 64'(att_d[1]);
            pr_reg[2][3] <= 64'(qv_reg[1])   * 64'(att_d[0]);
            pr_reg[3][0] <= 64'(c29_reg[33]) * 64'(att_d[3]);
            pr_reg[3][1] <= 64'(qv_reg[0])   * 64'(att_d[0]);
            pr_reg[3][2] <= 64'(qv_reg[1])   * 64'(att_d[1]);
            pr_reg[3][3] <= 64'(qv_reg[2])   * 64'(att_d[2]);

            for (int i = 0; i < 4; i++)
                acc_reg[i] <= acc_next[i];
            out_reg <= out_next;
        end
    end

`ifndef SYNTHESIS
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved while output stalled");

    a_octant_fold: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[36] |-> rp_reg <= OCT_HALF)
        else $error("folded angle beyond one octant");

    a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[59] |-> (hc_t_w[NUM_COS] <= ONE31) && (sm60_reg <= ONE31))
        else $error("sine or cosine magnitude above one");

    a_sin_q29: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[60] |-> (s29_reg <= 32'sh2000_0000) && (s29_reg >= -32'sh2000_0000))
        else $error("scaled sine out of range");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[92] && (dv_len_w[0][NUM_DIV] != '0) |->
            dv_rem_w[0][NUM_DIV] < dv_len_w[0][NUM_DIV])
        else $error("divider remainder not below divisor");

    a_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
        adv && vld_reg[92] && (dv_len_w[0][NUM_DIV] == '0) |=>
            (qv_reg[0] == '0) && (qv_reg[1] == '0) && (qv_reg[2] == '0))
        else $error("zero rotation gave nonzero vector part");
`endif

endmodule
`default_nettype wire

// ===== rtl/qaau_sqrt_cell.sv =====
`default_nettype none
module qaau_sqrt_cell (
    input  logic        clk,
    input  logic        en,
    input  logic [33:0] rem_in,
    input  logic [31:0] root_in,
    input  logic [63:0] v_in,
    output logic [33:0] rem_out,
    output logic [31:0] root_out,
    output logic [63:0] v_out
);
    logic [35:0] cur;
    logic [35:0] trial;
    logic        ge;
    logic [33:0] rem_reg, rem_next;
    logic [31:0] root_reg, root_next;
    logic [63:0] v_reg, v_next;

    // one root bit per cell, two radicand bits shifted in
    always_comb
    begin
        cur       = {rem_in, v_in[63:62]};
        trial     = {2'b00, root_in, 2'b01};
        ge        = (cur >= trial);
        rem_next  = ge ? 34'(cur - trial) : cur[33:0];
        root_next = {root_in[30:0], ge};
        v_next    = {v_in[61:0], 2'b00};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            v_reg    <= v_next;
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign v_out    = v_reg;
endmodule
`default_nettype wire

// ===== rtl/qaau_horner_cell.sv =====
`default_nettype none
module qaau_horner_cell (
    input  logic        clk,
    input  logic        en,
    input  logic [30:0] arg_in,
    input  logic [30:0] aux_in,
    input  logic [31:0] t_in,
    input  logic [7:0]  dvs,
    input  logic [31:0] recip,
    output logic [30:0] arg_out,
    output logic [30:0] aux_out,
    output logic [31:0] t_out
);
    import qaau_pkg::*;

    logic [62:0] prod_a;
    logic [62:0] prod_b;
    logic [31:0] qd_c;
    logic [31:0] r_c;
    logic [31:0] q_c;

    logic [30:0] arg_a_reg, aux_a_reg, y_a_reg;
    logic [30:0] arg_b_reg, aux_b_reg, y_b_reg, qe_b_reg;
    logic [30:0] arg_c_reg, aux_c_reg;
    logic [31:0] t_c_reg, t_c_next;

    // t' = 2^31 - ((arg * t) >> 31) / d, quotient by reciprocal plus one fixup
    always_comb
    begin
        prod_a   = 63'(arg_in) * 63'(t_in);
        prod_b   = 63'(y_a_reg) * 63'(recip);
        qd_c     = 32'(qe_b_reg) * 32'(dvs);
        r_c      = {1'b0, y_b_reg} - qd_c;
        q_c      = {1'b0, qe_b_reg} + ((r_c >= {24'd0, dvs}) ? 32'd1 : 32'd0);
        t_c_next = ONE31 - q_c;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            arg_a_reg <= arg_in;
            aux_a_reg <= aux_in;
            y_a_reg   <= prod_a[61:31];
            arg_b_reg <= arg_a_reg;
            aux_b_reg <= aux_a_reg;
            y_b_reg   <= y_a_reg;
            qe_b_reg  <= prod_b[62:32];
            arg_c_reg <= arg_b_reg;
            aux_c_reg <= aux_b_reg;
            t_c_reg   <= t_c_next;
        end
    end

    assign arg_out = arg_c_reg;
    assign aux_out = aux_c_reg;
    assign t_out   = t_c_reg;
endmodule
`default_nettype wire

// ===== rtl/qaau_div_cell.sv =====
`default_nettype none
module qaau_div_cell (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] rem_in,
    input  logic [29:0] num_in,
    input  logic [29:0] quo_in,
    input  logic [31:0] len_in,
    input  logic        neg_in,
    output logic [31:0] rem_out,
    output logic [29:0] num_out,
    output logic [29:0] quo_out,
    output logic [31:0] len_out,
    output logic        neg_out
);
    logic [32:0] cur;
    logic        ge;
    logic [31:0] rem_reg, rem_next;
    logic [29:0] num_reg, quo_reg;
    logic [31:0] len_reg;
    logic        neg_reg;

    // restoring step: remainder stays below the divisor
    always_comb
    begin
        cur      = {rem_in, num_in[29]};
        ge       = (cur >= {1'b0, len_in});
        rem_next = ge ? 32'(cur - {1'b0, len_in}) : cur[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            num_reg <= {num_in[28:0], 1'b0};
            quo_reg <= {quo_in[28:0], ge};
            len_reg <= len_in;
            neg_reg <= neg_in;
        end
    end

    assign rem_out = rem_reg;
    assign num_out = num_reg;
    assign quo_out = quo_reg;
    assign len_out = len_reg;
    assign neg_out = neg_reg;
endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none
module tb_top;
    import qaau_pkg::*;

    localparam int N_RANDOM  = 800;
    localparam int LATENCY   = 97;
    localparam int MAX_CYCLE = 400000;

    typedef struct {
        in_item_t  stim;
        bit        typed;
        out_item_t want;
    } dir_row_t;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    in_item_t  req;
    logic      rsp_valid;
    logic      rsp_ready;
    out_item_t rsp;

    quaternion_axis_angle_update dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    in_item_t  stim_q[$];
    bit        typed_q[$];
    out_item_t typed_want_q[$];
    out_item_t quat_expect_q[$];
    int        n_items;
    int        n_directed;
    int        sent;
    int        cycles;
    int        errors;
    bit        stim_ready;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [63:0] isqrt_u64(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] horner_poly(logic [63:0] x2, bit use_cos);
        logic [63:0] t;
        logic [63:0] d;
        int n;
        t = 64'd1 << 31;
        n = use_cos ? NUM_COS : NUM_SIN;
        for (int i = 0; i < n; i++)
        begin
            d = use_cos ? 64'(COS_DIV[i]) : 64'(SIN_DIV[i]);
            t = (64'd1 << 31) - ((x2 * t) >> 31) / d;
        end
        return t;
    endfunction

    function automatic longint round_clamp(longint v);
        longint t;
        longint r;
        t = v + (64'sd1 <<< 28);
        r = t >>> 29;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r;
    endfunction

    function automatic out_item_t rotate_attitude(in_item_t it);
        longint      rv[3];
        longint      a[4];
        longint      qv[3];
        longint      s29;
        longint      c29;
        longint      p;
        logic [63:0] sum;
        logic [63:0] len;
        logic [63:0] phase;
        logic [63:0] rem;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] sm;
        logic [63:0] cm;
        logic [63:0] tmp;
        logic [63:0] m;
        logic [1:0]  quad;
        bit          swap;
        out_item_t   o;
        rv[0] = it.rot_x;
        rv[1] = it.rot_y;
        rv[2] = it.rot_z;
        a[0] = it.att_x;
        a[1] = it.att_y;
        a[2] = it.att_z;
        a[3] = it.att_w;
        sum = 0;
        for (int i = 0; i < 3; i++) sum = sum + 64'(rv[i] * rv[i]);
        len = isqrt_u64(sum);
        phase = (len * 64'd5 + ((len * 64'd399252338) >> 32)) & 64'hFFFF_FFFF;
        quad = phase[31:30];
        rem = phase & 64'h3FFF_FFFF;
        swap = rem > (64'd1 << 29);
        if (swap) rem = (64'd1 << 30) - rem;
        x = (rem * 64'd13493037704) >> 32;
        x2 = (x * x) >> 31;
        cm = horner_poly(x2, 1'b1);
        sm = (x * horner_poly(x2, 1'b0)) >> 31;
        if (swap)
        begin
            tmp = sm;
            sm = cm;
            cm = tmp;
        end
        // quadrant picks signs and the sin/cos swap
        case (quad)
            2'd0: begin s29 = (sm + 2) >> 2;    c29 = (cm + 2) >> 2;    end
            2'd1: begin s29 = (cm + 2) >> 2;    c29 = -((sm + 2) >> 2); end
            2'd2: begin s29 = -((sm + 2) >> 2); c29 = -((cm + 2) >> 2); end
            default: begin s29 = -((cm + 2) >> 2); c29 = (sm + 2) >> 2; end
        endcase
        for (int i = 0; i < 3; i++)
        begin
            if (len == 0)
                qv[i] = 0;
            else
            begin
                p = s29 * rv[i];
                m = (p < 0) ? 64'(-p) : 64'(p);
                qv[i] = (p < 0) ? -longint'(m / len) : longint'(m / len);
            end
        end
        o.new_x = 32'(round_clamp(c29 * a[0] + qv[0] * a[3] + qv[1] * a[2] - qv[2] * a[1]));
        o.new_y = 32'(round_clamp(c29 * a[1] + qv[1] * a[3] + qv[2] * a[0] - qv[0] * a[2]));
        o.new_z = 32'(round_clamp(c29 * a[2] + qv[2] * a[3] + qv[0] * a[1] - qv[1] * a[0]));
        o.new_w = 32'(round_clamp(c29 * a[3] - qv[0] * a[0] - qv[1] * a[1] - qv[2] * a[2]));
        return o;
    endfunction

    function automatic logic [31:0] rand_rot();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) return 32'd0;
        if (pick < 5) return 32'($signed($urandom_range(268435456)) - 134217728);
        if (pick < 7) return 32'($signed($urandom_range(1073741824)) - 536870912);
        return $urandom;
    endfunction

    function automatic logic [31:0] rand_att(bit wild);
        if (wild) return $urandom;
        return 32'($signed($urandom_range(1073741824)) - 536870912);
    endfunction

    // directed rows, then random items
    initial
    begin
        dir_row_t  rows[$];
        dir_row_t  r;
        in_item_t  s;
        bit        wild;
        localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
        localparam logic [31:0] MINV = 32'h8000_0000;
        localparam logic [31:0] ONE29 = 32'h2000_0000;
        // zero rotation: identity, output equals attitude
        r.typed = 1'b1;
        r.stim = '{0, 0, 0, ONE29, 32'd0, 32'd0, 32'd0};
        r.want = '{ONE29, 32'd0, 32'd0, 32'd0};
        rows.push_back(r);
        r.stim = '{0, 0, 0, MAXV, MINV, MAXV, MINV};
        r.want = '{MAXV, MINV, MAXV, MINV};
        rows.push_back(r);
        r.stim = '{0, 0, 0, MINV, MINV, MINV, MINV};
        r.want = '{MINV, MINV, MINV, MINV};
        rows.push_back(r);
        r.stim = '{0, 0, 0, 32'hFFFF_FFFF, 32'd1, 32'h1234_5678, 32'hEDCB_A988};
        r.want = '{32'hFFFF_FFFF, 32'd1, 32'h1234_5678, 32'hEDCB_A988};
        rows.push_back(r);
        r.typed = 1'b0;
        r.want = '0;
        r.stim = '{MAXV, MAXV, MAXV, ONE29, ONE29, ONE29, ONE29};
        rows.push_back(r);
        r.stim = '{MINV, MINV, MINV, MAXV, MAXV, MAXV, MAXV};
        rows.push_back(r);
        r.stim = '{MINV, 0, 0, 0, 0, 0, ONE29};
        rows.push_back(r);
        r.stim = '{MAXV, 0, 0, MINV, MINV, MINV, MINV};
        rows.push_back(r);
        r.stim = '{0, 32'd1, 0, 0, 0, 0, ONE29};
        rows.push_back(r);
        r.stim = '{0, 0, 32'hFFFF_FFFF, ONE29, 0, 0, 0};
        rows.push_back(r);
        // near pi/2, pi, 3pi/2 and the octant boundary
        r.stim = '{32'd210828714, 0, 0, 0, 0, 0, ONE29};
        rows.push_back(r);
        r.stim = '{0, 32'd421657428, 0, 0, ONE29, 0, 0};
        rows.push_back(r);
        r.stim = '{0, 0, 32'd632486142, 0, 0, ONE29, 0};
        rows.push_back(r);
        r.stim = '{32'd105414357, 0, 0, 0, 0, 0, ONE29};
        rows.push_back(r);
        r.stim = '{32'd74540000, 32'd74540000, 32'hFB8E_5E00, ONE29, MINV, 0, MAXV};
        rows.push_back(r);
        // saturation with a large attitude
        r.stim = '{32'd60000000, 32'd30000000, 32'd20000000, MAXV, MAXV, MAXV, MAXV};
        rows.push_back(r);
        foreach (rows[i])
        begin
            stim_q.push_back(rows[i].stim);
            typed_q.push_back(rows[i].typed);
            typed_want_q.push_back(rows[i].want);
        end
        n_directed = rows.size();
        for (int i = 0; i < N_RANDOM; i++)
        begin
            wild = ($urandom_range(3) == 0);
            s.rot_x = rand_rot();
            s.rot_y = rand_rot();
            s.rot_z = rand_rot();
            s.att_x = rand_att(wild);
            s.att_y = rand_att(wild);
            s.att_z = rand_att(wild);
            s.att_w = rand_att(wild);
            stim_q.push_back(s);
            typed_q.push_back(1'b0);
            typed_want_q.push_back('0);
        end
        n_items = stim_q.size();
        stim_ready = 1'b1;
    end

    initial
    begin
        sent = 0;
        cycles = 0;
        errors = 0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_ready = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        wait (stim_ready && sent == n_items && quat_expect_q.size() == 0);
        repeat (LATENCY + 20) @(posedge clk);
        if (errors == 0)
            $display("** quaternion_axis_angle_update: PASSED **");
        else
            $display("** quaternion_axis_angle_update: FAILED **");
        $finish;
    end

    // response check, then stimulus drive, in one process so queue reads agree
    always @(posedge clk)
    begin
        int        send_idle;
        int        recv_idle;
        bit        hold;
        out_item_t want;
        cycles++;
        if (cycles > MAX_CYCLE)
        begin
            $display("** quaternion_axis_angle_update: FAILED **");
            $finish;
        end
        else if (rst_n && stim_ready)
        begin
            if (sent < n_items / 3)
            begin
                send_idle = 26;
                recv_idle = 50;
            end
            else if (sent < 2 * n_items / 3)
            begin
                send_idle = 50;
                recv_idle = 26;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            if (rsp_valid && rsp_ready)
            begin
                if (quat_expect_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected item %h", $time, rsp);
                end
                else
                begin
                    want = quat_expect_q.pop_front();
                    if (rsp.new_x !== want.new_x)
                        $display("%0t: new_x expected %h actual %h", $time, want.new_x, rsp.new_x);
                    if (rsp.new_y !== want.new_y)
                        $display("%0t: new_y expected %h actual %h", $time, want.new_y, rsp.new_y);
                    if (rsp.new_z !== want.new_z)
                        $display("%0t: new_z expected %h actual %h", $time, want.new_z, rsp.new_z);
                    if (rsp.new_w !== want.new_w)
                        $display("%0t: new_w expected %h actual %h", $time, want.new_w, rsp.new_w);
                    if (rsp !== want) errors++;
                end
            end
            rsp_ready <= ($urandom_range(99) >= recv_idle);

            if (req_valid && req_ready)
            begin
                if (typed_q[sent])
                    quat_expect_q.push_back(typed_want_q[sent]);
                else
                    quat_expect_q.push_back(rotate_attitude(stim_q[sent]));
                sent++;
            end
            // drain everything once after the directed part
            hold = (sent == n_directed) && (quat_expect_q.size() != 0);
            if (!(req_valid && !req_ready))
            begin
                if (sent < n_items && !hold && $urandom_range(99) >= send_idle)
                begin
                    req_valid <= 1'b1;
                    req <= stim_q[sent];
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/qaau_pkg.sv
rtl/qaau_sqrt_cell.sv
rtl/qaau_horner_cell.sv
rtl/qaau_div_cell.sv
rtl/quaternion_axis_angle_update.sv
test/tb_top.sv
